// ===== rtl/core/bmru_pkg.sv =====
`timescale 1ns / 1ps

package bmru_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int KIND_W       = 3;
  localparam int KEY_W        = 32;
  localparam int PAY_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_OUT_W  = 4;

  typedef enum logic [KIND_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_UPDATE  = 3'd1,
    OP_PROMOTE = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_LOOKUP  = 3'd4
  } op_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NULL_REJ  = 2'd2
  } status_e_t;

  // what one cell does at the next edge
  typedef enum logic [2:0] {
    CMD_HOLD       = 3'd0,
    CMD_COMPARE    = 3'd1,
    CMD_TAKE_LEFT  = 3'd2,
    CMD_TAKE_RIGHT = 3'd3,
    CMD_LOAD       = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] id;
    logic [PAY_W-1:0] payload;
    logic             hit;
  } entry_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic             occ;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] new_id;
    logic [PAY_W-1:0] new_payload;
  } cell_ctl_t;

endpackage

// ===== rtl/core/bounded_mru_list_unit.sv =====
`timescale 1ns / 1ps

// channel | ports                                          | direction
// input   | in_valid, in_stall, in_kind, in_key, in_payload | item in, stall out
// result  | out_valid, out_stall, out_status, out_result_key,
//         | out_result_payload, out_entry_count             | item out, stall in
//
// for an item, the accept edge loads every cell's id compare, and the next
// edge moves the cells and loads the result register
// remove stays in its execute state while an entry matches, one entry leaves
// the chain per cycle
// synchronous active-low reset empties the list and clears the id counter
// a new item is taken only while the chain is idle and the result register
// is empty or being taken, so a stalled result holds the input side

module bounded_mru_list_unit import bmru_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [KEY_W-1:0]       in_key,
  input  logic [PAY_W-1:0]       in_payload,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    out_status,
  output logic [KEY_W-1:0]       out_result_key,
  output logic [PAY_W-1:0]       out_result_payload,
  output logic [COUNT_OUT_W-1:0] out_entry_count
);

  localparam int FW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                 state_r, state_nxt;
  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [PAY_W-1:0]       pay_r, pay_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;
  logic [KEY_W-1:0]       ctr_r, ctr_nxt;
  logic                   removed_r, removed_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_e_t              status_r, status_nxt;
  logic [KEY_W-1:0]       rkey_r, rkey_nxt;
  logic [PAY_W-1:0]       rpay_r, rpay_nxt;
  logic [COUNT_OUT_W-1:0] cnt_r, cnt_nxt;

  logic                   accept;
  logic [KEY_W-1:0]       front_id;
  logic [PAY_W-1:0]       front_pay;
  logic [PAY_W-1:0]       sel_pay;
  logic [CAPACITY-1:0]    hit_vec;
  logic [CAPACITY-1:0]    first_vec;
  logic [CAPACITY-1:0]    upto_vec;
  logic [CAPACITY-1:0]    from_vec;
  logic                   any_hit;

  cell_cmd_t              cmd [CAPACITY];
  cell_ctl_t              ctl [CAPACITY];
  entry_t                 cq  [CAPACITY];

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // hit bits travel with the entries; lowest set bit is the most recent match
  assign any_hit   = |hit_vec;
  assign first_vec = hit_vec & (~hit_vec + CAPACITY'(1));
  assign upto_vec  = first_vec | (first_vec - CAPACITY'(1));
  assign from_vec  = ~(first_vec - CAPACITY'(1));

  always_comb begin
    sel_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_vec[i]) begin
        sel_pay = sel_pay | cq[i].payload;
      end
    end
  end

  // cell chain, entry 0 is the most recent
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;

    if (i == 0) begin : g_head
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = cq[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = cq[i+1];
    end

    assign hit_vec[i] = cq[i].hit;

    assign ctl[i] = '{cmd: cmd[i],
                      occ: (fill_r > FW'(i)),
                      key: key_nxt,
                      new_id: front_id,
                      new_payload: front_pay};

    bmru_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[i]),
      .left_i  (left_e),
      .right_i (right_e),
      .q       (cq[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    fill_nxt      = fill_r;
    ctr_nxt       = ctr_r;
    removed_nxt   = removed_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    rkey_nxt      = rkey_r;
    rpay_nxt      = rpay_r;
    cnt_nxt       = cnt_r;
    front_id      = key_r;
    front_pay     = pay_r;
    for (int i = 0; i < CAPACITY; i++) begin
      cmd[i] = CMD_HOLD;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          // every cell compares its id with the new key
          kind_nxt    = in_kind;
          key_nxt     = in_key;
          pay_nxt     = in_payload;
          removed_nxt = 1'b0;
          state_nxt   = S_EXEC;
          for (int i = 0; i < CAPACITY; i++) begin
            cmd[i] = CMD_COMPARE;
          end
        end
      end

      S_EXEC: begin
        logic finish;
        finish     = 1'b1;
        status_nxt = ST_DONE;
        rkey_nxt   = key_r;
        rpay_nxt   = '0;

        unique case (kind_r)
          OP_INSERT: begin
            if (pay_r == '0) begin
              status_nxt = ST_NULL_REJ;
              rkey_nxt   = '0;
            end else begin
              // whole chain shifts back, the oldest entry falls off the end
              ctr_nxt  = ctr_r + KEY_W'(1);
              front_id = ctr_nxt;
              rkey_nxt = ctr_nxt;
              if (fill_r < FW'(CAPACITY)) begin
                fill_nxt = fill_r + FW'(1);
              end
              for (int i = 0; i < CAPACITY; i++) begin
                cmd[i] = (i == 0) ? CMD_LOAD : CMD_TAKE_LEFT;
              end
            end
          end

          OP_UPDATE, OP_PROMOTE: begin
            if (!any_hit) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              // matched id equals the key, only the payload needs choosing
              front_pay = (kind_r == OP_UPDATE) ? pay_r : sel_pay;
              for (int i = 0; i < CAPACITY; i++) begin
                if (upto_vec[i]) begin
                  cmd[i] = (i == 0) ? CMD_LOAD : CMD_TAKE_LEFT;
                end
              end
            end
          end

          OP_REMOVE: begin
            if (any_hit) begin
              // close the gap at the first match, one match per cycle
              finish      = 1'b0;
              removed_nxt = 1'b1;
              fill_nxt    = fill_r - FW'(1);
              for (int i = 0; i < CAPACITY; i++) begin
                if (from_vec[i]) begin
                  cmd[i] = CMD_TAKE_RIGHT;
                end
              end
            end else if (!removed_r) begin
              status_nxt = ST_NOT_FOUND;
            end
          end

          OP_LOOKUP: begin
            if (any_hit) begin
              rpay_nxt = sel_pay;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end

          default: begin
          end
        endcase

        if (finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          cnt_nxt       = COUNT_OUT_W'(fill_nxt);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      ctr_r       <= '0;
      removed_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ctr_r       <= ctr_nxt;
      removed_r   <= removed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    key_r    <= key_nxt;
    pay_r    <= pay_nxt;
    status_r <= status_nxt;
    rkey_r   <= rkey_nxt;
    rpay_r   <= rpay_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_result_key     = rkey_r;
  assign out_result_payload = rpay_r;
  assign out_entry_count    = cnt_r;

endmodule

// ===== rtl/core/bmru_cell.sv =====
`timescale 1ns / 1ps

module bmru_cell import bmru_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    left_i,
  input  entry_t    right_i,
  output entry_t    q
);

  logic [KEY_W-1:0] id_r, id_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;
  logic             hit_r, hit_nxt;

  always_comb begin
    id_nxt  = id_r;
    pay_nxt = pay_r;
    hit_nxt = hit_r;
    unique case (ctl.cmd)
      CMD_HOLD: begin
      end
      CMD_COMPARE: begin
        hit_nxt = ctl.occ && (id_r == ctl.key);
      end
      CMD_TAKE_LEFT: begin
        id_nxt  = left_i.id;
        pay_nxt = left_i.payload;
        hit_nxt = left_i.hit;
      end
      CMD_TAKE_RIGHT: begin
        id_nxt  = right_i.id;
        pay_nxt = right_i.payload;
        hit_nxt = right_i.hit;
      end
      CMD_LOAD: begin
        id_nxt  = ctl.new_id;
        pay_nxt = ctl.new_payload;
        hit_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    pay_r <= pay_nxt;
  end

  assign q = '{id: id_r, payload: pay_r, hit: hit_r};

endmodule

// ===== test/bounded_mru_list_checker.sv =====
`timescale 1ns / 1ps

module bounded_mru_list_checker import bmru_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [KEY_W-1:0]       in_key,
  input  logic [PAY_W-1:0]       in_payload,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [STATUS_W-1:0]    out_status,
  input  logic [KEY_W-1:0]       out_result_key,
  input  logic [PAY_W-1:0]       out_result_payload,
  input  logic [COUNT_OUT_W-1:0] out_entry_count,
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);

  typedef struct packed {
    status_e_t              status;
    logic [KEY_W-1:0]       key;
    logic [PAY_W-1:0]       payload;
    logic [COUNT_OUT_W-1:0] count;
  } mru_result_t;

  // shadow list, position 0 most recent
  logic [KEY_W-1:0] list_ids  [CAPACITY];
  logic [PAY_W-1:0] list_pays [CAPACITY];
  int               held;
  logic [KEY_W-1:0] last_id;

  mru_result_t result_q [$];
  int          errors = 0;
  int          seen   = 0;

  task automatic report(input string msg);
    if (errors < 40) $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int find_entry(input logic [KEY_W-1:0] key);
    for (int i = 0; i < held; i++)
      if (list_ids[i] == key) return i;
    return -1;
  endfunction

  function automatic void move_to_front(input int pos);
    logic [KEY_W-1:0] id;
    logic [PAY_W-1:0] pl;
    id = list_ids[pos];
    pl = list_pays[pos];
    for (int i = pos; i > 0; i--) begin
      list_ids[i]  = list_ids[i-1];
      list_pays[i] = list_pays[i-1];
    end
    list_ids[0]  = id;
    list_pays[0] = pl;
  endfunction

  task automatic apply_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                          input logic [PAY_W-1:0] pl, output mru_result_t r);
    int pos;
    int kept;
    r.status  = ST_DONE;
    r.key     = key;
    r.payload = '0;
    case (kind)
      OP_INSERT: begin
        if (pl == '0) begin
          r.status = ST_NULL_REJ;
          r.key    = '0;
        end else begin
          last_id = last_id + 1'b1;
          if (held < CAPACITY) held++;
          for (int i = held - 1; i > 0; i--) begin
            list_ids[i]  = list_ids[i-1];
            list_pays[i] = list_pays[i-1];
          end
          list_ids[0]  = last_id;
          list_pays[0] = pl;
          r.key        = last_id;
        end
      end
      OP_UPDATE: begin
        pos = find_entry(key);
        if (pos < 0) r.status = ST_NOT_FOUND;
        else begin
          list_pays[pos] = pl;
          move_to_front(pos);
        end
      end
      OP_PROMOTE: begin
        pos = find_entry(key);
        if (pos < 0) r.status = ST_NOT_FOUND;
        else move_to_front(pos);
      end
      OP_REMOVE: begin
        kept = 0;
        for (int i = 0; i < held; i++) begin
          if (list_ids[i] != key) begin
            list_ids[kept]  = list_ids[i];
            list_pays[kept] = list_pays[i];
            kept++;
          end
        end
        if (kept == held) r.status = ST_NOT_FOUND;
        held = kept;
      end
      OP_LOOKUP: begin
        pos = find_entry(key);
        if (pos < 0) r.status = ST_NOT_FOUND;
        else r.payload = list_pays[pos];
      end
      default: ;
    endcase
    r.count = COUNT_OUT_W'(held);
  endtask

  always @(posedge clk) begin : watch
    mru_result_t want;
    if (!rst_n) begin
      held    = 0;
      last_id = '0;
      result_q.delete();
    end else begin
      // result side first, a result never belongs to an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report($sformatf("result with no item outstanding, key %h", out_result_key));
        end else begin
          want = result_q.pop_front();
          if (out_status !== want.status)
            report($sformatf("status got %0d expected %0d, key %h",
                             out_status, want.status, want.key));
          if (out_result_key !== want.key)
            report($sformatf("result_key got %h expected %h", out_result_key, want.key));
          if (out_result_payload !== want.payload)
            report($sformatf("result_payload got %h expected %h, key %h",
                             out_result_payload, want.payload, want.key));
          if (out_entry_count !== want.count)
            report($sformatf("entry_count got %0d expected %0d, key %h",
                             out_entry_count, want.count, want.key));
          seen++;
        end
      end
      if (in_valid && !in_stall) begin
        apply_op(in_kind, in_key, in_payload, want);
        result_q.push_back(want);
      end
    end
    fail_count <= errors;
    pending    <= result_q.size();
    checked    <= seen;
  end

endmodule

// ===== test/bounded_mru_list_unit_test.sv =====
`timescale 1ns / 1ps

module bounded_mru_list_unit_test;
  import bmru_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 12;
  // the limit leaves a wide margin over the slowest run
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int TAIL_CYCLES  = 24;
  localparam int PHASE_ITEMS  = 165;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic [KIND_W-1:0]      in_kind   = '0;
  logic [KEY_W-1:0]       in_key    = '0;
  logic [PAY_W-1:0]       in_payload = '0;
  logic                   out_stall = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [KEY_W-1:0]       out_result_key;
  logic [PAY_W-1:0]       out_result_payload;
  logic [COUNT_OUT_W-1:0] out_entry_count;

  // idle mix, percent of cycles each side idles
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  // long receiver hold-off, requested by toggling hold_req
  logic hold_req  = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  int   cycles = 0;
  // ids handed out so far, the block numbers accepted inserts from 1
  int   ids_issued = 0;
  int   sent_by_kind [8];

  int   fail_count;
  int   pending;
  int   checked;

  bounded_mru_list_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_key             (in_key),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_key     (out_result_key),
    .out_result_payload (out_result_payload),
    .out_entry_count    (out_entry_count)
  );

  bounded_mru_list_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_key             (in_key),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_key     (out_result_key),
    .out_result_payload (out_result_payload),
    .out_entry_count    (out_entry_count),
    .fail_count         (fail_count),
    .pending            (pending),
    .checked            (checked)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off counted down here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // offer one item, with a random gap ahead of it, and wait until it is taken
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pl);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_key     <= key;
    in_payload <= pl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == OP_INSERT && pl != '0) ids_issued++;
    sent_by_kind[kind]++;
  endtask

  // stop offering and wait until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // an id that is likely still in the list: one of the last ten handed out
  function automatic logic [KEY_W-1:0] recent_key();
    int k;
    k = ids_issued - $urandom_range(0, 9);
    if (k < 1) k = 1;
    return KEY_W'(k);
  endfunction

  // mostly well-formed traffic on live ids, some misses and unused kinds as noise
  task automatic random_item();
    int               pick;
    logic [PAY_W-1:0] pl;
    pick = $urandom_range(0, 99);
    pl   = $urandom;
    if (pick < 30) begin
      // an occasional null insert
      if ($urandom_range(0, 15) == 0) pl = '0;
      send_item(OP_INSERT, $urandom, pl);
    end else if (pick < 45) begin
      // update also stores a null payload now and then
      if ($urandom_range(0, 7) == 0) pl = '0;
      send_item(OP_UPDATE, recent_key(), pl);
    end else if (pick < 60) begin
      send_item(OP_PROMOTE, recent_key(), pl);
    end else if (pick < 75) begin
      send_item(OP_REMOVE, recent_key(), pl);
    end else if (pick < 90) begin
      send_item(OP_LOOKUP, recent_key(), pl);
    end else if (pick < 95) begin
      // keys across the whole range, almost always a miss
      send_item(KIND_W'($urandom_range(OP_UPDATE, OP_LOOKUP)), $urandom, pl);
    end else begin
      send_item(KIND_W'($urandom_range(5, 7)), $urandom, pl);
    end
  endtask

  initial begin
    foreach (sent_by_kind[i]) sent_by_kind[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, light idling on both sides
    tx_idle_pct <= 20;
    rx_idle_pct <= 20;
    // misses on an empty list
    send_item(OP_LOOKUP,  '0,           32'h1234_5678);
    send_item(OP_REMOVE,  32'hFFFF_FFFF, '0);
    send_item(OP_PROMOTE, 32'd1,         '0);
    // null insert is rejected and takes no id
    send_item(OP_INSERT,  32'hFFFF_FFFF, '0);
    send_item(OP_INSERT,  '0,            32'hFFFF_FFFF);
    send_item(OP_INSERT,  32'hFFFF_FFFF, 32'h0000_0001);
    send_item(OP_LOOKUP,  32'd1,         '0);
    // promote of the front entry, then of the back entry
    send_item(OP_PROMOTE, 32'd2,         '0);
    send_item(OP_PROMOTE, 32'd1,         '0);
    // update with a null payload is stored as is
    send_item(OP_UPDATE,  32'd2,         '0);
    send_item(OP_LOOKUP,  32'd2,         32'hFFFF_FFFF);
    // unused kinds change nothing
    send_item(KIND_W'(5), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_W'(6), 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_item(KIND_W'(7), '0,            '0);
    // remove, then remove the same id again
    send_item(OP_REMOVE,  32'd1,         '0);
    send_item(OP_REMOVE,  32'd1,         '0);
    // overfill so the oldest entries fall off the back
    for (int i = 0; i < 9; i++) send_item(OP_INSERT, $urandom, 32'h100 + i);
    send_item(OP_LOOKUP,  32'd2,         '0);
    send_item(OP_UPDATE,  32'd11,        32'hFFFF_FFFF);
    drain_results();

    // sender busy, receiver stalls often
    tx_idle_pct <= 8;
    rx_idle_pct <= 70;
    for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    drain_results();

    // sender gappy, receiver mostly ready
    tx_idle_pct <= 70;
    rx_idle_pct <= 8;
    for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    drain_results();

    // back to back, with one long hold-off so the block backs up into its input
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == 40) hold_req <= ~hold_req;
      random_item();
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d insert, %0d update, %0d promote, %0d remove, %0d lookup, %0d unused",
             sent_by_kind[OP_INSERT], sent_by_kind[OP_UPDATE], sent_by_kind[OP_PROMOTE],
             sent_by_kind[OP_REMOVE], sent_by_kind[OP_LOOKUP],
             sent_by_kind[5] + sent_by_kind[6] + sent_by_kind[7]);
    $display("%0d results checked, %0d ids issued, three idle mixes and a long hold-off",
             checked, ids_issued);
    if (fail_count == 0 && pending == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bmru_pkg.sv
rtl/core/bmru_cell.sv
rtl/core/bounded_mru_list_unit.sv
test/bounded_mru_list_checker.sv
test/bounded_mru_list_unit_test.sv
